// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/bgb_pkg.sv =====
// ----------------------------------------------------------------------------
// bgb_pkg
// Types, constants and helpers shared by the glyph blitter modules.
// ----------------------------------------------------------------------------
package bgb_pkg;

  localparam int MAX_GLYPH_DIM = 255;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 15;
  localparam int OFFSET_W      = 30;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BUFFER_WIDTH_RST  = 15'd320;
  localparam logic [CFG_DATA_W-1:0] BUFFER_HEIGHT_RST = 15'd200;

  localparam logic [7:0] MASK_FULL = 8'hFF;
  localparam logic [7:0] MASK_ODD  = 8'hAA;
  localparam logic [7:0] MASK_EVEN = 8'h55;

  typedef struct packed {
    logic               glyph_start;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic signed [15:0] origin_top;
    logic signed [15:0] origin_left;
    logic [7:0]         ink_color;
    logic               greyed;
    logic [7:0]         bitmap_byte;
  } bgb_in_t;

  typedef struct packed {
    logic                write_enable;
    logic                out_of_bounds;
    logic [OFFSET_W-1:0] buffer_offset;
    logic [7:0]          pixel_color;
    logic                last_of_byte;
    logic                glyph_done;
  } bgb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } bgb_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic prep;
    logic emit;
  } bgb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic go_active;
    logic last_pix;
    logic out_free;
  } bgb_status_t;

  function automatic logic [7:0] clamp_dim(input logic [7:0] v);
    return (32'(v) > MAX_GLYPH_DIM) ? 8'(MAX_GLYPH_DIM) : v;
  endfunction

endpackage

// ===== rtl/core/bgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgb_ctrl
// Sequencer: accept a byte and, if a glyph is active, prepare its row values, then emit its pixels.
// ----------------------------------------------------------------------------
module bgb_ctrl import bgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bgb_status_t status,
  output bgb_cmd_t    cmd
);

  bgb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.go_active) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.last_pix) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.prep   = (state_r == ST_PREP);
    cmd.emit   = (state_r == ST_EMIT) && status.out_free;
  end

endmodule

// ===== rtl/core/bgb_datapath.sv =====
// ----------------------------------------------------------------------------
// bgb_datapath
// Glyph state, buffer registers, row precompute and per-pixel result register.
// ----------------------------------------------------------------------------
module bgb_datapath import bgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bgb_cmd_t              cmd,
  output bgb_status_t           status,
  input  bgb_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bgb_out_t              out_data
);

  // Buffer geometry
  logic [14:0] bw_r, bh_r;

  // Glyph state
  logic        active_r;
  logic [7:0]  col_r, row_r;
  logic [7:0]  w_r, h_r, color_r;
  logic [15:0] top_r, left_r;
  logic        greyed_r;
  logic [7:0]  byte_r;

  // Per-byte precompute
  logic [7:0]  bits_r;
  logic [3:0]  count_r;
  logic        row_end_r, glyph_end_r, y_in_r;
  logic [29:0] row_base_r;
  logic [2:0]  idx_r;

  // Result register
  logic        out_valid_r;
  bgb_out_t    out_data_r;

  logic        start_active;
  logic [16:0] scr_y, scr_x;
  logic [7:0]  mask, cnt_full;
  logic [3:0]  count;
  logic        row_end, glyph_end, y_in, x_in, pix_set, in_buf, last_pix;
  logic [29:0] row_base;
  bgb_out_t    pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= BUFFER_WIDTH_RST;
      bh_r <= BUFFER_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_WIDTH:  bw_r <= cfg_data;
        REG_BUFFER_HEIGHT: bh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign start_active = (clamp_dim(in_data.glyph_width) != 8'd0) &&
                        (clamp_dim(in_data.glyph_height) != 8'd0);

  // Row values: screen row, dither mask, pixel count, row/glyph end, row bounds, row base
  always_comb begin
    scr_y = {top_r[15], top_r} + {9'd0, row_r};
    if (greyed_r) begin
      mask = scr_y[0] ? MASK_ODD : MASK_EVEN;
    end else begin
      mask = MASK_FULL;
    end
    cnt_full  = w_r - col_r;
    count     = (cnt_full > 8'd8) ? 4'd8 : cnt_full[3:0];
    row_end   = ({1'b0, col_r} + {5'd0, count}) >= {1'b0, w_r};
    glyph_end = row_end && (({1'b0, row_r} + 9'd1) >= {1'b0, h_r});
    y_in      = !scr_y[16] && (scr_y[15:0] < {1'b0, bh_r});
    row_base  = 30'(scr_y[14:0]) * 30'(bw_r);
  end

  // Pixel values for the current column
  always_comb begin
    scr_x    = {left_r[15], left_r} + {9'd0, col_r} + {14'd0, idx_r};
    x_in     = !scr_x[16] && (scr_x[15:0] < {1'b0, bw_r});
    pix_set  = bits_r[3'd7 - idx_r];
    in_buf   = x_in && y_in_r;
    last_pix = ({1'b0, idx_r} == (count_r - 4'd1));
    pix.write_enable  = pix_set && in_buf;
    pix.out_of_bounds = pix_set && !in_buf;
    pix.buffer_offset = (pix_set && in_buf) ? (row_base_r + 30'(scr_x[14:0])) : '0;
    pix.pixel_color   = (pix_set && in_buf) ? color_r : 8'd0;
    pix.last_of_byte  = last_pix;
    pix.glyph_done    = last_pix && glyph_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      w_r      <= '0;
      h_r      <= '0;
      top_r    <= '0;
      left_r   <= '0;
      color_r  <= '0;
      greyed_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.accept) begin
      if (in_data.glyph_start) begin
        w_r      <= clamp_dim(in_data.glyph_width);
        h_r      <= clamp_dim(in_data.glyph_height);
        top_r    <= in_data.origin_top;
        left_r   <= in_data.origin_left;
        color_r  <= in_data.ink_color;
        greyed_r <= in_data.greyed;
        col_r    <= '0;
        row_r    <= '0;
        active_r <= start_active;
      end
      idx_r <= '0;
    end else if (cmd.emit) begin
      if (last_pix) begin
        idx_r <= '0;
        if (row_end_r) begin
          col_r <= '0;
          if (glyph_end_r) begin
            active_r <= 1'b0;
            row_r    <= '0;
          end else begin
            row_r <= row_r + 8'd1;
          end
        end else begin
          col_r <= col_r + 8'd8;
        end
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_data.bitmap_byte;
    end
    if (cmd.prep) begin
      bits_r      <= byte_r & mask;
      count_r     <= count;
      row_end_r   <= row_end;
      glyph_end_r <= glyph_end;
      y_in_r      <= y_in;
      row_base_r  <= row_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.go_active = in_data.glyph_start ? start_active : active_r;
  assign status.last_pix  = last_pix;
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== rtl/core/bitmap_glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter
// Expands 1-bit glyph bitmap bytes into byte-per-pixel frame buffer writes.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+-------------------
//   input   | in_valid / in_stall / in_data  | in        | header + bitmap byte
//   output  | out_valid / out_stall / out_data | out     | one pixel result
//   config  | cfg_valid / cfg_ready / cfg_*  | in        | buffer width/height
//
// Sequence: a byte that starts or continues a glyph is accepted, then the row
// multiply (row * buffer_width) runs in the prepare state, then its N pixel
// columns (1..8, normally 8) leave one pixel per cycle while out_stall is low,
// via the single result register. A byte that gives no pixels is only accepted.
// Reset: synchronous, active low; buffer size returns to 320 x 200, no glyph.
// Stalls: out_stall holds the result register and pauses pixel emission;
// in_stall is high from the cycle after a glyph byte is taken until its last pixel
// is loaded into the result register.
//
module bitmap_glyph_blitter import bgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bgb_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bgb_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bgb_cmd_t    cmd;
  bgb_status_t status;

  // Config writes land directly in the buffer geometry registers.
  assign cfg_ready = 1'b1;

  // Sequencer: idle -> prepare row -> emit pixels
  bgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Glyph state, row precompute and pixel result register
  bgb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/bgb_checker.sv =====
// ----------------------------------------------------------------------------
// bgb_checker
// Port-level checks for the glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgb_checker import bgb_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input bgb_out_t              out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  `ASSERT_IMPL(a_we_oob_excl, clk, rst_n, out_valid, !(out_data.write_enable && out_data.out_of_bounds))
  `ASSERT_IMPL(a_unwritten_zero, clk, rst_n, out_valid && !out_data.write_enable, (out_data.buffer_offset == '0) && (out_data.pixel_color == 8'd0))
  `ASSERT_IMPL(a_done_is_last, clk, rst_n, out_valid && out_data.glyph_done, out_data.last_of_byte)

endmodule

bind bitmap_glyph_blitter bgb_checker u_bgb_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the glyph blitter: drives header and bitmap bytes,
// predicts every pixel result in a scoreboard and compares them in order.
// ----------------------------------------------------------------------------
module testbench import bgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected pixel stream of the blitter, built one bitmap byte at a time.
  class blit_scoreboard;
    int buf_w = int'(BUFFER_WIDTH_RST);
    int buf_h = int'(BUFFER_HEIGHT_RST);
    int failures = 0;
    bgb_out_t expected_pixels[$];

    bit                 active = 0;
    int                 col_pos = 0;
    int                 row_pos = 0;
    int                 lat_w = 0;
    int                 lat_h = 0;
    logic signed [15:0] lat_top = '0;
    logic signed [15:0] lat_left = '0;
    logic [7:0]         lat_color = '0;
    bit                 lat_grey = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_BUFFER_WIDTH) begin
        buf_w = int'(val);
      end else begin
        buf_h = int'(val);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Latch the header on a start byte, then expand the masked byte.
    function void note_byte(bgb_in_t it);
      int         scr_y;
      int         scr_x;
      int         count;
      longint     prod;
      logic [7:0] mask;
      logic [7:0] bits;
      bit         row_end;
      bit         glyph_end;
      bit         in_buf;
      bgb_out_t   r;
      if (it.glyph_start) begin
        lat_w = (int'(it.glyph_width) > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : int'(it.glyph_width);
        lat_h = (int'(it.glyph_height) > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM
                                                         : int'(it.glyph_height);
        lat_top   = it.origin_top;
        lat_left  = it.origin_left;
        lat_color = it.ink_color;
        lat_grey  = it.greyed;
        col_pos   = 0;
        row_pos   = 0;
        active    = (lat_w != 0) && (lat_h != 0);
      end
      if (!active) return;

      scr_y = int'(lat_top) + row_pos;
      if (lat_grey) begin
        mask = (scr_y & 1) ? MASK_ODD : MASK_EVEN;
      end else begin
        mask = MASK_FULL;
      end
      bits = it.bitmap_byte & mask;

      count = lat_w - col_pos;
      if (count > 8) count = 8;
      row_end   = (col_pos + count >= lat_w);
      glyph_end = row_end && (row_pos + 1 >= lat_h);

      for (int i = 0; i < count; i++) begin
        scr_x  = int'(lat_left) + col_pos + i;
        in_buf = (scr_x >= 0) && (scr_x < buf_w) && (scr_y >= 0) && (scr_y < buf_h);
        r = '0;
        r.write_enable  = bits[7-i] && in_buf;
        r.out_of_bounds = bits[7-i] && !in_buf;
        if (r.write_enable) begin
          prod = longint'(scr_y) * longint'(buf_w) + longint'(scr_x);
          r.buffer_offset = prod[OFFSET_W-1:0];
          r.pixel_color   = lat_color;
        end
        r.last_of_byte = (i == count - 1);
        r.glyph_done   = r.last_of_byte && glyph_end;
        expected_pixels.push_back(r);
      end

      if (row_end) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 8'hFF;
        if (glyph_end) begin
          active  = 0;
          row_pos = 0;
        end
      end else begin
        col_pos = (col_pos + 8) & 8'hFF;
      end
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_pixel(bgb_out_t got);
      bgb_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel result, expected none, actual 0x%0h", $time, got);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      field_check("write_enable",  want.write_enable,  got.write_enable);
      field_check("out_of_bounds", want.out_of_bounds, got.out_of_bounds);
      field_check("buffer_offset", want.buffer_offset, got.buffer_offset);
      field_check("pixel_color",   want.pixel_color,   got.pixel_color);
      field_check("last_of_byte",  want.last_of_byte,  got.last_of_byte);
      field_check("glyph_done",    want.glyph_done,    got.glyph_done);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  bgb_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  bgb_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blit_scoreboard sb;
  int             send_gap_pct;
  int             recv_stall_pct;

  bitmap_glyph_blitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard ceiling on the run; a hung handshake ends here.
  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver back-pressure: an independent coin per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Predict on every byte the block takes; values here are pre-edge samples.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_data);
  end

  // Check every pixel the bench takes off the output.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  // Random filler for fields the block does not look at on this item.
  function automatic bgb_in_t noise_item();
    bgb_in_t it;
    it.glyph_start  = 1'b0;
    it.glyph_width  = 8'($urandom);
    it.glyph_height = 8'($urandom);
    it.origin_top   = 16'($urandom);
    it.origin_left  = 16'($urandom);
    it.ink_color    = 8'($urandom);
    it.greyed       = 1'($urandom);
    it.bitmap_byte  = 8'($urandom);
    return it;
  endfunction

  function automatic bgb_in_t header_item(int w, int h, int top, int left, int color,
                                          bit grey, int bits);
    bgb_in_t it;
    it = '0;
    it.glyph_start  = 1'b1;
    it.glyph_width  = 8'(w);
    it.glyph_height = 8'(h);
    it.origin_top   = 16'(top);
    it.origin_left  = 16'(left);
    it.ink_color    = 8'(color);
    it.greyed       = grey;
    it.bitmap_byte  = 8'(bits);
    return it;
  endfunction

  function automatic bgb_in_t body_item(int bits);
    bgb_in_t it;
    it = noise_item();
    it.bitmap_byte = 8'(bits);
    return it;
  endfunction

  // Present one item, optionally after an idle gap, and hold it until taken.
  // Returns on the edge that accepts it, so the next call drives only once.
  task automatic send_item(input bgb_in_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold off until every predicted pixel has come out. Step
  // one edge first so the byte taken on the calling edge is already noted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Registers change only when idle: drain, then let a trailing byte with no
  // pixels finish before writing.
  task automatic reconfigure(input int w, input int h);
    drain();
    repeat (12) @(posedge clk);
    write_reg(REG_BUFFER_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_BUFFER_HEIGHT, CFG_DATA_W'(h));
    cfg_valid <= 1'b0;
  endtask

  // Leave valid high on return; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Hand-picked glyphs under the reset buffer size of 320 x 200.
  task automatic run_directed();
    // Byte while idle: no pixels expected.
    send_item(body_item(8'hFF));
    // Empty glyphs, zero width and zero height.
    send_item(header_item(0, 5, 10, 10, 8'h11, 1'b0, 8'hFF));
    send_item(header_item(5, 0, 10, 10, 8'h11, 1'b0, 8'hFF));
    // Plain 8 x 2 glyph at the origin, full ink.
    send_item(header_item(8, 2, 0, 0, 8'hFF, 1'b0, 8'hFF));
    send_item(body_item(8'h81));
    // Narrow glyph straddling the right edge in the bottom row, ink 0.
    send_item(header_item(3, 1, 199, 318, 8'h00, 1'b0, 8'hE0));
    // Greyed glyph across an odd and an even screen row, partly above the top.
    send_item(header_item(8, 2, -1, -4, 8'h5C, 1'b1, 8'hFF));
    send_item(body_item(8'hFF));
    // Largest glyph at extreme origins, aborted by a new start after two bytes.
    send_item(header_item(255, 255, 32767, -32768, 8'h00, 1'b0, 8'h00));
    send_item(body_item(8'hFF));
    // Nine-wide row padded to two bytes, the second covering one column.
    send_item(header_item(9, 1, 10, 311, 8'hA7, 1'b0, 8'hFF));
    send_item(body_item(8'h80));
    // Opposite extreme origins, all pixels out of bounds.
    send_item(header_item(16, 1, -32768, 32767, 8'h3C, 1'b1, 8'h5A));
    send_item(body_item(8'hA5));
    // A clear byte in a glyph landing in the last buffer row.
    send_item(header_item(8, 1, 199, 0, 8'hC3, 1'b0, 8'h00));
  endtask

  // One glyph with random content, placed mostly in or near the buffer.
  task automatic send_glyph(input int w, input int h, input bit cut, inout int sent);
    bgb_in_t it;
    int      total;
    int      n;
    int      top;
    int      left;
    total = ((w + 7) / 8) * h;
    n = cut ? $urandom_range(1, total) : total;
    if ($urandom_range(99) < 15) begin
      top  = int'($urandom);
      left = int'($urandom);
    end else begin
      top  = int'($urandom_range(0, sb.buf_h + 2 * h)) - h;
      left = int'($urandom_range(0, sb.buf_w + 2 * w)) - w;
    end
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      if (k == 0) begin
        it = header_item(w, h, top, left, int'(it.ink_color), it.greyed,
                         int'(it.bitmap_byte));
      end
      send_item(it);
      sent++;
    end
  endtask

  // Mostly well-formed glyphs; the rest aborted glyphs, empty headers and
  // stray bytes. Only glyph bytes count toward the total.
  task automatic run_random(input int items);
    int sent;
    int pick;
    int w;
    int h;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(25, 255);
        h = 1;
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 6);
      end
      if (pick < 75) begin
        send_glyph(w, h, 1'b0, sent);
      end else if (pick < 85) begin
        send_glyph(w, h, 1'b1, sent);
      end else if (pick < 92) begin
        send_item(header_item($urandom_range(1) ? 0 : w, $urandom_range(1) ? 0 : h,
                              $urandom, $urandom, $urandom, $urandom, $urandom));
        send_item(header_item(0, 0, 0, 0, 0, 1'b0, 8'hFF));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(body_item($urandom));
      end
      if ($urandom_range(99) < 5) drain();
    end
  endtask

  initial begin
    sb             = new();
    send_gap_pct   = 37;
    recv_stall_pct = 53;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_BUFFER_WIDTH;
    cfg_data       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    run_directed();
    reconfigure(40, 30);
    run_random(40);

    // Swap the idling rates; drain once mid-stream.
    send_gap_pct   = 53;
    recv_stall_pct = 37;
    reconfigure(32767, 32767);
    run_random(15);
    drain();
    run_random(15);
    reconfigure(1, 1);
    run_random(15);

    // Full throughput on both sides; zero-sized buffers flag every set pixel.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    reconfigure(0, 120);
    run_random(15);
    reconfigure(200, 0);
    run_random(15);
    reconfigure(320, 200);
    run_random(30);

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bgb_pkg.sv
rtl/core/bgb_ctrl.sv
rtl/core/bgb_datapath.sv
rtl/core/bitmap_glyph_blitter.sv
rtl/core/bgb_checker.sv
tb/testbench.sv
